FILE: src/spid_pkg.sv
// Shared types and constants for the per-motor speed PID current command unit.
// No dependencies; every other file of the block refers to it by scoped names.
package spid_pkg;

  // Field widths fixed by the interface.
  localparam int MOTOR_W   = 3;
  localparam int SPEED_W   = 16;
  localparam int CMD_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int THR_W     = 16;
  localparam int ICLAMP_W  = 31;
  localparam int CCLAMP_W  = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  // Internal arithmetic widths.
  localparam int ERR_W  = SPEED_W + 1;
  localparam int DERR_W = ERR_W + 1;
  localparam int ACC_W  = 32;

  // Motor count default.
  localparam int MOTOR_COUNT_DEF = 8;

  // Integral decay of about 0.4 in Q0.15, and the Q8.8 gain shift.
  localparam int                DECAY_SHIFT = 15;
  localparam logic [DECAY_SHIFT-1:0] DECAY_MUL = 15'd13107;
  localparam int                GAIN_SHIFT  = 8;

  // Register reset values.
  localparam logic [THR_W-1:0]    THR_RESET    = 16'hFFFF;
  localparam logic [ICLAMP_W-1:0] ICLAMP_RESET = 31'h7FFF_FFFF;
  localparam logic [CCLAMP_W-1:0] CCLAMP_RESET = 15'd10000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_SEP_THRESHOLD = 3'd3,
    REG_INTEG_CLAMP   = 3'd4,
    REG_CURRENT_CLAMP = 3'd5
  } cfg_reg_t;

  // Result of the integrator step for one item.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [ACC_W-1:0]  acc;
  } integ_step_t;

endpackage

FILE: src/spid_in_if.sv
// Input channel of the speed PID unit: one speed sample for one motor.
// Depends on spid_pkg for field widths.
interface spid_in_if;
  logic                                valid;
  logic                                ready;
  logic [spid_pkg::MOTOR_W-1:0]        motor_index;
  logic signed [spid_pkg::SPEED_W-1:0] target_speed;
  logic signed [spid_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, motor_index, target_speed, measured_speed, input ready);
  modport sink (input valid, motor_index, target_speed, measured_speed, output ready);
endinterface

FILE: src/spid_out_if.sv
// Output channel of the speed PID unit: one current command per sample.
// Depends on spid_pkg for field widths.
interface spid_out_if;
  logic                              valid;
  logic                              ready;
  logic [spid_pkg::MOTOR_W-1:0]      motor_out;
  logic signed [spid_pkg::CMD_W-1:0] current_command;
  logic                              saturated;

  modport source (output valid, motor_out, current_command, saturated, input ready);
  modport sink (input valid, motor_out, current_command, saturated, output ready);
endinterface

FILE: src/spid_integ.sv
// Per-motor loop state (integral sum and last error) and the integrator step
// with integral separation. Depends on spid_pkg.
module spid_integ #(
  parameter int MOTOR_COUNT = spid_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                update,
  input  logic [spid_pkg::MOTOR_W-1:0]        motor,
  input  logic signed [spid_pkg::SPEED_W-1:0] target_speed,
  input  logic signed [spid_pkg::SPEED_W-1:0] measured_speed,
  input  logic [spid_pkg::THR_W-1:0]          threshold,
  output logic                                in_range,
  output spid_pkg::integ_step_t               step
);

  localparam int IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ACC_W = spid_pkg::ACC_W;
  localparam int ERR_W = spid_pkg::ERR_W;
  localparam int MulW = ACC_W + spid_pkg::DECAY_SHIFT;

  logic signed [ACC_W-1:0] integral_sum [MOTOR_COUNT];
  logic signed [ERR_W-1:0] last_error [MOTOR_COUNT];

  logic [4:0]              motor_wide;
  logic [IdxW-1:0]         idx;
  logic signed [ACC_W-1:0] acc_old;
  logic signed [ERR_W-1:0] err_old;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        mag;
  logic signed [MulW-1:0]  decay_prod;
  logic signed [ACC_W:0]   acc_add;
  logic signed [ACC_W-1:0] acc_new;

  // Motor lookup; an index past the motor count reads zero and is never written.
  assign motor_wide = {2'b00, motor};
  assign idx        = motor_wide[IdxW-1:0];
  assign in_range   = motor_wide < 5'(MOTOR_COUNT);
  assign acc_old    = in_range ? integral_sum[idx] : '0;
  assign err_old    = in_range ? last_error[idx] : '0;

  // Speed error and its magnitude.
  assign err = ERR_W'(target_speed) - ERR_W'(measured_speed);
  assign mag = err[ERR_W-1] ? (~err + 1'b1) : err;

  // Decay path and saturating accumulate path.
  assign decay_prod = acc_old * $signed({1'b0, spid_pkg::DECAY_MUL});
  assign acc_add    = {acc_old[ACC_W-1], acc_old} + (ACC_W+1)'(err);

  always_comb begin
    if (mag >= {1'b0, threshold}) begin
      acc_new = decay_prod[spid_pkg::DECAY_SHIFT +: ACC_W];
    end else if (acc_add[ACC_W] != acc_add[ACC_W-1]) begin
      acc_new = acc_add[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_add[ACC_W-1:0];
    end
  end

  assign step.err  = err;
  assign step.derr = spid_pkg::DERR_W'(err) - spid_pkg::DERR_W'(err_old);
  assign step.acc  = acc_new;

  // State update as the item leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        integral_sum[i] <= '0;
        last_error[i]   <= '0;
      end
    end else if (update && in_range) begin
      integral_sum[idx] <= acc_new;
      last_error[idx]   <= err;
    end
  end

endmodule

FILE: src/speed_pid_current_command_unit.sv
// A result passes the input, integrator, product and output registers in turn
// after its input transaction is accepted. Throughput: one transaction per cycle;
// the per-motor integrator state is read and written back as an item leaves the
// input register, and a stage only waits when the one after it is full.
// Reset: gains cleared, threshold 65535, integral clamp 2^31-1, current clamp
// 10000, every motor's integral sum and last error zero, pipeline empty.
module speed_pid_current_command_unit #(
  parameter int MOTOR_COUNT = spid_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [spid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spid_pkg::CFG_DATA_W-1:0]       cfg_data,
  spid_in_if.sink                               in_ch,
  spid_out_if.source                            out_ch
);

  localparam int ERR_W  = spid_pkg::ERR_W;
  localparam int DERR_W = spid_pkg::DERR_W;
  localparam int ACC_W  = spid_pkg::ACC_W;
  localparam int PP_W   = ERR_W + spid_pkg::GAIN_W + 1;
  localparam int IP_W   = ACC_W + spid_pkg::GAIN_W + 1;
  localparam int DP_W   = DERR_W + spid_pkg::GAIN_W + 1;
  localparam int SUM_W  = IP_W + 1;
  localparam int CMD_FULL_W = SUM_W - spid_pkg::GAIN_SHIFT;
  localparam int CMD_W  = spid_pkg::CMD_W;

  // Configuration registers.
  logic [spid_pkg::GAIN_W-1:0]   prop_gain;
  logic [spid_pkg::GAIN_W-1:0]   integ_gain;
  logic [spid_pkg::GAIN_W-1:0]   deriv_gain;
  logic [spid_pkg::THR_W-1:0]    separation_threshold;
  logic [spid_pkg::ICLAMP_W-1:0] integ_clamp;
  logic [spid_pkg::CCLAMP_W-1:0] current_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain            <= '0;
      integ_gain           <= '0;
      deriv_gain           <= '0;
      separation_threshold <= spid_pkg::THR_RESET;
      integ_clamp          <= spid_pkg::ICLAMP_RESET;
      current_clamp        <= spid_pkg::CCLAMP_RESET;
    end else if (cfg_we) begin
      case (spid_pkg::cfg_reg_t'(cfg_index))
        spid_pkg::REG_PROP_GAIN:     prop_gain <= cfg_data[spid_pkg::GAIN_W-1:0];
        spid_pkg::REG_INTEG_GAIN:    integ_gain <= cfg_data[spid_pkg::GAIN_W-1:0];
        spid_pkg::REG_DERIV_GAIN:    deriv_gain <= cfg_data[spid_pkg::GAIN_W-1:0];
        spid_pkg::REG_SEP_THRESHOLD: separation_threshold <= cfg_data[spid_pkg::THR_W-1:0];
        spid_pkg::REG_INTEG_CLAMP:   integ_clamp <= cfg_data[spid_pkg::ICLAMP_W-1:0];
        spid_pkg::REG_CURRENT_CLAMP: current_clamp <= cfg_data[spid_pkg::CCLAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage valids and per-stage ready; a stage loads when it is empty or drains.
  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready   = !out_valid || out_ch.ready;
  assign s3_ready    = !s3_valid || out_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Input register.
  logic [spid_pkg::MOTOR_W-1:0]        s1_motor;
  logic signed [spid_pkg::SPEED_W-1:0] s1_target;
  logic signed [spid_pkg::SPEED_W-1:0] s1_measured;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_motor    <= in_ch.motor_index;
      s1_target   <= in_ch.target_speed;
      s1_measured <= in_ch.measured_speed;
    end
  end

  // Integrator step; state is written as the item moves on.
  logic                  s1_in_range;
  spid_pkg::integ_step_t s1_step;

  spid_integ #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_integ (
    .clk            (clk),
    .rst            (rst),
    .update         (s1_valid && s2_ready),
    .motor          (s1_motor),
    .target_speed   (s1_target),
    .measured_speed (s1_measured),
    .threshold      (separation_threshold),
    .in_range       (s1_in_range),
    .step           (s1_step)
  );

  logic [spid_pkg::MOTOR_W-1:0] s2_motor;
  logic                         s2_in_range;
  spid_pkg::integ_step_t        s2_step;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_motor    <= s1_motor;
      s2_in_range <= s1_in_range;
      s2_step     <= s1_step;
    end
  end

  // Clamp the integral and form the three gain products.
  logic signed [ACC_W-1:0] iclamp_pos;
  logic signed [ACC_W-1:0] iclamp_neg;
  logic signed [ACC_W-1:0] acc_clamped;

  assign iclamp_pos = $signed({1'b0, integ_clamp});
  assign iclamp_neg = -iclamp_pos;

  always_comb begin
    if (s2_step.acc > iclamp_pos) begin
      acc_clamped = iclamp_pos;
    end else if (s2_step.acc < iclamp_neg) begin
      acc_clamped = iclamp_neg;
    end else begin
      acc_clamped = s2_step.acc;
    end
  end

  logic [spid_pkg::MOTOR_W-1:0] s3_motor;
  logic                         s3_in_range;
  logic signed [PP_W-1:0]       s3_pp;
  logic signed [IP_W-1:0]       s3_ip;
  logic signed [DP_W-1:0]       s3_dp;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_motor    <= s2_motor;
      s3_in_range <= s2_in_range;
      s3_pp       <= $signed({1'b0, prop_gain}) * s2_step.err;
      s3_ip       <= $signed({1'b0, integ_gain}) * acc_clamped;
      s3_dp       <= $signed({1'b0, deriv_gain}) * s2_step.derr;
    end
  end

  // Sum, drop the Q8.8 fraction and clip to the current limit.
  logic signed [SUM_W-1:0]      total;
  logic signed [CMD_FULL_W-1:0] cmd_full;
  logic signed [CMD_FULL_W-1:0] lim_pos;
  logic signed [CMD_FULL_W-1:0] lim_neg;
  logic                         clip_hi;
  logic                         clip_lo;
  logic signed [CMD_W-1:0]      cmd_next;
  logic                         sat_next;

  assign total    = SUM_W'(s3_pp) + SUM_W'(s3_ip) + SUM_W'(s3_dp);
  assign cmd_full = total[SUM_W-1:spid_pkg::GAIN_SHIFT];
  assign lim_pos  = CMD_FULL_W'(current_clamp);
  assign lim_neg  = -lim_pos;
  assign clip_hi  = cmd_full > lim_pos;
  assign clip_lo  = cmd_full < lim_neg;

  always_comb begin
    if (!s3_in_range) begin
      cmd_next = '0;
      sat_next = 1'b0;
    end else if (clip_hi) begin
      cmd_next = lim_pos[CMD_W-1:0];
      sat_next = 1'b1;
    end else if (clip_lo) begin
      cmd_next = lim_neg[CMD_W-1:0];
      sat_next = 1'b1;
    end else begin
      cmd_next = cmd_full[CMD_W-1:0];
      sat_next = 1'b0;
    end
  end

  // Output register.
  logic                    out_in_range;
  logic [spid_pkg::MOTOR_W-1:0] out_motor;
  logic signed [CMD_W-1:0] out_cmd;
  logic                    out_sat;

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_in_range <= s3_in_range;
      out_motor    <= s3_motor;
      out_cmd      <= cmd_next;
      out_sat      <= sat_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.motor_out       = out_motor;
  assign out_ch.current_command = out_cmd;
  assign out_ch.saturated       = out_sat;

  // A motor without loop state always yields a zero, unclipped command.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_in_range |-> out_cmd == '0 && !out_sat)
    else $error("out-of-range motor produced a nonzero command");

  // A clipped command sits exactly on the current limit.
  a_sat_on_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |->
      out_cmd == $signed({1'b0, current_clamp}) || out_cmd == -$signed({1'b0, current_clamp}))
    else $error("saturated command is not at the current limit");

  // An unclipped command never exceeds the current limit.
  a_unsat_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_sat |->
      out_cmd <= $signed({1'b0, current_clamp}) && out_cmd >= -$signed({1'b0, current_clamp}))
    else $error("unclipped command lies outside the current limit");

  // The input is only held off when every stage is occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && s2_valid && s3_valid && out_valid && !out_ch.ready)
    else $error("input stalled while the pipeline had a free stage");

endmodule
